@@ rtl/letterbox_nearest_scaler_rgb565_assert.svh @@
// Assertion macros for the scaler's checker file.
`ifndef LETTERBOX_NEAREST_SCALER_RGB565_ASSERT_SVH
`define LETTERBOX_NEAREST_SCALER_RGB565_ASSERT_SVH

// Same-cycle implication, masked while reset is held.
`define LBS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is held.
`define LBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also runs through reset.
`define LBS_ASSERT_RAW_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/lbs_pkg.sv @@
// Shared constants, types and codes of the letterbox scaler.
package lbs_pkg;

    // frame store dimensions
    localparam int SRC_MAX_WIDTH  = 512;
    localparam int SRC_MAX_HEIGHT = 512;
    localparam int XW             = $clog2(SRC_MAX_WIDTH);
    localparam int YW             = $clog2(SRC_MAX_HEIGHT);
    localparam int DEPTH          = SRC_MAX_WIDTH * SRC_MAX_HEIGHT;
    localparam int ADDR_W         = $clog2(DEPTH);

    // field and register widths
    localparam int SRC_W     = 10;
    localparam int SCR_W     = 11;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int COORD_W   = 10;
    localparam int RGBA_W    = 24;
    localparam int PIX_W     = 16;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;

    // register clamp limits
    localparam int SRC_LIMIT = 512;
    localparam int SCR_LIMIT = 1024;

    // fixed point
    localparam int Q16     = 16;
    localparam int DIV_W   = SRC_W + Q16;
    localparam int SCALE_W = DIV_W;
    localparam int OFF_W   = COORD_W;
    localparam int PROD_W  = OFF_W + SCALE_W;
    localparam int S_W     = PROD_W - Q16;
    localparam int CNT_W   = $clog2(DIV_W);

    // decoupling queue
    localparam int FIFO_DEPTH = 4;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SRC_W = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_H = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCR_W = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCR_H = 2'd3;

    // register reset values
    localparam logic [SRC_W-1:0] RST_SRC_W = 10'd320;
    localparam logic [SRC_W-1:0] RST_SRC_H = 10'd240;
    localparam logic [SCR_W-1:0] RST_SCR_W = 11'd424;
    localparam logic [SCR_W-1:0] RST_SCR_H = 11'd240;

    // item opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [1:0] {
        K_WRITE,
        K_READ,
        K_BORDER
    } t_kind;

    // one queued command for the back end
    typedef struct packed {
        t_kind             kind;
        logic [ADDR_W-1:0] addr;
        logic [RGBA_W-1:0] rgba;
    } t_cmd;

    // geometry derived from the registers
    typedef struct packed {
        logic               valid;
        logic [SCALE_W-1:0] scale;
        logic [SCR_W-1:0]   start_x;
        logic [SCR_W-1:0]   end_x;
        logic [SCR_W-1:0]   start_y;
        logic [SCR_W-1:0]   end_y;
        logic [XW-1:0]      lim_x_m1;
        logic [YW-1:0]      lim_y_m1;
    } t_geom;

endpackage

@@ rtl/lbs_geom.sv @@
// Configuration registers and sequential geometry solver with a shared divider.
module lbs_geom (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lbs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lbs_pkg::CFG_W-1:0]     i_cfg_data,
    output lbs_pkg::t_geom                o_geom
);

    typedef enum logic [2:0] {
        G_KX,
        G_KY,
        G_DW,
        G_DH,
        G_EDGE,
        G_DONE
    } t_gstate;

    t_gstate                        r_state;
    logic                           r_load;
    logic                           r_valid;
    logic [lbs_pkg::CNT_W-1:0]      r_cnt;
    logic [lbs_pkg::DIV_W-1:0]      r_rem;
    logic [lbs_pkg::DIV_W-1:0]      r_quo;
    logic [lbs_pkg::DIV_W-1:0]      r_dvs;
    logic [lbs_pkg::SRC_W-1:0]      r_src_w;
    logic [lbs_pkg::SRC_W-1:0]      r_src_h;
    logic [lbs_pkg::SCR_W-1:0]      r_scr_w;
    logic [lbs_pkg::SCR_W-1:0]      r_scr_h;
    logic [lbs_pkg::SCALE_W-1:0]    r_kx;
    logic [lbs_pkg::SCALE_W-1:0]    r_scale;
    logic [lbs_pkg::SCR_W-1:0]      r_dest_w;
    logic [lbs_pkg::SCR_W-1:0]      r_dest_h;
    logic [lbs_pkg::SCR_W-1:0]      r_start_x;
    logic [lbs_pkg::SCR_W-1:0]      r_end_x;
    logic [lbs_pkg::SCR_W-1:0]      r_start_y;
    logic [lbs_pkg::SCR_W-1:0]      r_end_y;

    logic [lbs_pkg::SRC_W-1:0]      sw;
    logic [lbs_pkg::SRC_W-1:0]      sh;
    logic [lbs_pkg::SCR_W-1:0]      scw;
    logic [lbs_pkg::SCR_W-1:0]      sch;
    logic [lbs_pkg::DIV_W-1:0]      dividend;
    logic [lbs_pkg::DIV_W-1:0]      divisor;
    logic [lbs_pkg::DIV_W:0]        shifted;
    logic                           ge;
    logic [lbs_pkg::DIV_W-1:0]      n_rem;
    logic [lbs_pkg::DIV_W-1:0]      n_quo;
    logic                           last;
    logic [lbs_pkg::SCALE_W-1:0]    n_scale;
    logic [lbs_pkg::SCR_W-1:0]      n_dest_w;
    logic [lbs_pkg::SCR_W-1:0]      n_dest_h;
    logic [lbs_pkg::SCR_W-1:0]      n_start_x;
    logic [lbs_pkg::SCR_W-1:0]      n_start_y;
    logic [31:0]                    lim_x;
    logic [31:0]                    lim_y;

    // clamp registers into their legal ranges
    always_comb begin
        sw  = (r_src_w == '0) ? lbs_pkg::SRC_W'(1) :
              (32'(r_src_w) > lbs_pkg::SRC_LIMIT) ? lbs_pkg::SRC_W'(lbs_pkg::SRC_LIMIT) : r_src_w;
        sh  = (r_src_h == '0) ? lbs_pkg::SRC_W'(1) :
              (32'(r_src_h) > lbs_pkg::SRC_LIMIT) ? lbs_pkg::SRC_W'(lbs_pkg::SRC_LIMIT) : r_src_h;
        scw = (r_scr_w == '0) ? lbs_pkg::SCR_W'(1) :
              (32'(r_scr_w) > lbs_pkg::SCR_LIMIT) ? lbs_pkg::SCR_W'(lbs_pkg::SCR_LIMIT) : r_scr_w;
        sch = (r_scr_h == '0) ? lbs_pkg::SCR_W'(1) :
              (32'(r_scr_h) > lbs_pkg::SCR_LIMIT) ? lbs_pkg::SCR_W'(lbs_pkg::SCR_LIMIT) : r_scr_h;
    end

    // operands of the current division
    always_comb begin
        unique case (r_state)
            G_KX: begin
                dividend = lbs_pkg::DIV_W'(sw) << lbs_pkg::Q16;
                divisor  = lbs_pkg::DIV_W'(scw);
            end
            G_KY: begin
                dividend = lbs_pkg::DIV_W'(sh) << lbs_pkg::Q16;
                divisor  = lbs_pkg::DIV_W'(sch);
            end
            G_DW: begin
                dividend = lbs_pkg::DIV_W'(sw) << lbs_pkg::Q16;
                divisor  = r_scale;
            end
            G_DH: begin
                dividend = lbs_pkg::DIV_W'(sh) << lbs_pkg::Q16;
                divisor  = r_scale;
            end
            default: begin
                dividend = '0;
                divisor  = '0;
            end
        endcase
    end

    // restoring divider, one quotient bit a cycle
    always_comb begin
        shifted = {r_rem, r_quo[lbs_pkg::DIV_W-1]};
        ge      = shifted >= {1'b0, r_dvs};
        n_rem   = ge ? lbs_pkg::DIV_W'(shifted - {1'b0, r_dvs}) : shifted[lbs_pkg::DIV_W-1:0];
        n_quo   = {r_quo[lbs_pkg::DIV_W-2:0], ge};
        last    = (r_cnt == lbs_pkg::CNT_W'(lbs_pkg::DIV_W - 1));
    end

    always_comb begin
        n_scale = (r_kx > n_quo) ? r_kx : n_quo;
        if (n_scale == '0) begin
            n_scale = lbs_pkg::SCALE_W'(1);
        end
        n_dest_w  = (n_quo > lbs_pkg::DIV_W'(scw)) ? scw : n_quo[lbs_pkg::SCR_W-1:0];
        n_dest_h  = (n_quo > lbs_pkg::DIV_W'(sch)) ? sch : n_quo[lbs_pkg::SCR_W-1:0];
        n_start_x = (scw - r_dest_w) >> 1;
        n_start_y = (sch - r_dest_h) >> 1;
        lim_x     = (32'(sw) < lbs_pkg::SRC_MAX_WIDTH)  ? 32'(sw) : lbs_pkg::SRC_MAX_WIDTH;
        lim_y     = (32'(sh) < lbs_pkg::SRC_MAX_HEIGHT) ? 32'(sh) : lbs_pkg::SRC_MAX_HEIGHT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_KX;
            r_load  <= 1'b1;
            r_valid <= 1'b0;
            r_cnt   <= '0;
            r_src_w <= lbs_pkg::RST_SRC_W;
            r_src_h <= lbs_pkg::RST_SRC_H;
            r_scr_w <= lbs_pkg::RST_SCR_W;
            r_scr_h <= lbs_pkg::RST_SCR_H;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lbs_pkg::REG_SRC_W: r_src_w <= i_cfg_data[lbs_pkg::SRC_W-1:0];
                lbs_pkg::REG_SRC_H: r_src_h <= i_cfg_data[lbs_pkg::SRC_W-1:0];
                lbs_pkg::REG_SCR_W: r_scr_w <= i_cfg_data;
                lbs_pkg::REG_SCR_H: r_scr_h <= i_cfg_data;
            endcase
            // any write restarts the solve
            r_state <= G_KX;
            r_load  <= 1'b1;
            r_valid <= 1'b0;
        end else begin
            unique case (r_state)
                G_KX, G_KY, G_DW, G_DH: begin
                    if (r_load) begin
                        r_rem  <= '0;
                        r_quo  <= dividend;
                        r_dvs  <= divisor;
                        r_cnt  <= '0;
                        r_load <= 1'b0;
                    end else begin
                        r_rem <= n_rem;
                        r_quo <= n_quo;
                        r_cnt <= r_cnt + 1'b1;
                        if (last) begin
                            r_load <= 1'b1;
                            unique case (r_state)
                                G_KX: begin
                                    r_kx    <= n_quo;
                                    r_state <= G_KY;
                                end
                                G_KY: begin
                                    r_scale <= n_scale;
                                    r_state <= G_DW;
                                end
                                G_DW: begin
                                    r_dest_w <= n_dest_w;
                                    r_state  <= G_DH;
                                end
                                default: begin
                                    r_dest_h <= n_dest_h;
                                    r_state  <= G_EDGE;
                                end
                            endcase
                        end
                    end
                end
                G_EDGE: begin
                    r_start_x <= n_start_x;
                    r_end_x   <= n_start_x + r_dest_w;
                    r_start_y <= n_start_y;
                    r_end_y   <= n_start_y + r_dest_h;
                    r_valid   <= 1'b1;
                    r_state   <= G_DONE;
                end
                G_DONE: begin
                    r_valid <= 1'b1;
                end
                default: begin
                    r_state <= G_KX;
                    r_load  <= 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        o_geom.valid    = r_valid;
        o_geom.scale    = r_scale;
        o_geom.start_x  = r_start_x;
        o_geom.end_x    = r_end_x;
        o_geom.start_y  = r_start_y;
        o_geom.end_y    = r_end_y;
        o_geom.lim_x_m1 = lbs_pkg::XW'(lim_x - 32'd1);
        o_geom.lim_y_m1 = lbs_pkg::YW'(lim_y - 32'd1);
    end

endmodule

@@ rtl/lbs_front.sv @@
// Front end: accepts items, classifies them and maps screen pixels to store addresses.
module lbs_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lbs_pkg::t_geom              i_geom,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_op,
    input  logic [lbs_pkg::COORD_W-1:0] i_cx,
    input  logic [lbs_pkg::COORD_W-1:0] i_cy,
    input  logic [lbs_pkg::RGBA_W-1:0]  i_rgba,
    output logic                        o_push,
    output lbs_pkg::t_cmd               o_cmd,
    input  logic                        i_full
);

    logic                          en;
    logic                          fire;
    logic [lbs_pkg::SCR_W-1:0]     px;
    logic [lbs_pkg::SCR_W-1:0]     py;
    logic [lbs_pkg::S_W-1:0]       s_x;
    logic [lbs_pkg::S_W-1:0]       s_y;
    logic [lbs_pkg::XW-1:0]        sx;
    logic [lbs_pkg::YW-1:0]        sy;

    // stage 1: classification and offsets
    logic                          r1_valid;
    logic                          r1_op;
    logic                          r1_wr_ok;
    logic                          r1_in_x;
    logic                          r1_in_y;
    logic [lbs_pkg::OFF_W-1:0]     r1_off_x;
    logic [lbs_pkg::OFF_W-1:0]     r1_off_y;
    logic [lbs_pkg::ADDR_W-1:0]    r1_waddr;
    logic [lbs_pkg::RGBA_W-1:0]    r1_rgba;

    // stage 2: scaled offsets
    logic                          r2_valid;
    logic                          r2_op;
    logic                          r2_wr_ok;
    logic                          r2_inside;
    logic [lbs_pkg::PROD_W-1:0]    r2_prod_x;
    logic [lbs_pkg::PROD_W-1:0]    r2_prod_y;
    logic [lbs_pkg::ADDR_W-1:0]    r2_waddr;
    logic [lbs_pkg::RGBA_W-1:0]    r2_rgba;

    assign en      = !(r2_valid && i_full);
    assign o_ready = en && i_geom.valid;
    assign fire    = i_valid && o_ready;
    assign px      = lbs_pkg::SCR_W'(i_cx);
    assign py      = lbs_pkg::SCR_W'(i_cy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= fire;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_op    <= i_op;
            r1_wr_ok <= (32'(i_cx) < lbs_pkg::SRC_MAX_WIDTH) &&
                        (32'(i_cy) < lbs_pkg::SRC_MAX_HEIGHT);
            // end never exceeds the screen size, so this also covers off-screen reads
            r1_in_x  <= (px >= i_geom.start_x) && (px < i_geom.end_x);
            r1_in_y  <= (py >= i_geom.start_y) && (py < i_geom.end_y);
            r1_off_x <= lbs_pkg::OFF_W'(px - i_geom.start_x);
            r1_off_y <= lbs_pkg::OFF_W'(py - i_geom.start_y);
            r1_waddr <= lbs_pkg::ADDR_W'(32'(i_cy) * lbs_pkg::SRC_MAX_WIDTH + 32'(i_cx));
            r1_rgba  <= i_rgba;

            r2_op     <= r1_op;
            r2_wr_ok  <= r1_wr_ok;
            r2_inside <= r1_in_x && r1_in_y;
            r2_prod_x <= lbs_pkg::PROD_W'(r1_off_x) * lbs_pkg::PROD_W'(i_geom.scale);
            r2_prod_y <= lbs_pkg::PROD_W'(r1_off_y) * lbs_pkg::PROD_W'(i_geom.scale);
            r2_waddr  <= r1_waddr;
            r2_rgba   <= r1_rgba;
        end
    end

    // drop the fraction and clamp to the last stored column and row
    always_comb begin
        s_x = r2_prod_x[lbs_pkg::PROD_W-1:lbs_pkg::Q16];
        s_y = r2_prod_y[lbs_pkg::PROD_W-1:lbs_pkg::Q16];
        sx  = (s_x > lbs_pkg::S_W'(i_geom.lim_x_m1)) ? i_geom.lim_x_m1 : s_x[lbs_pkg::XW-1:0];
        sy  = (s_y > lbs_pkg::S_W'(i_geom.lim_y_m1)) ? i_geom.lim_y_m1 : s_y[lbs_pkg::YW-1:0];
    end

    always_comb begin
        o_cmd.rgba = r2_rgba;
        priority if (r2_op == lbs_pkg::OP_WRITE) begin
            o_cmd.kind = lbs_pkg::K_WRITE;
            o_cmd.addr = r2_waddr;
        end else if (r2_inside) begin
            o_cmd.kind = lbs_pkg::K_READ;
            o_cmd.addr = lbs_pkg::ADDR_W'(32'(sy) * lbs_pkg::SRC_MAX_WIDTH + 32'(sx));
        end else begin
            o_cmd.kind = lbs_pkg::K_BORDER;
            o_cmd.addr = '0;
        end
        // writes outside the store vanish here
        o_push = r2_valid && !i_full && ((r2_op == lbs_pkg::OP_READ) || r2_wr_ok);
    end

endmodule

@@ rtl/lbs_fifo.sv @@
// Short command queue between front and back end.
module lbs_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lbs_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output lbs_pkg::t_cmd o_cmd,
    output logic          o_empty
);

    lbs_pkg::t_cmd               r_q [lbs_pkg::FIFO_DEPTH];
    logic [lbs_pkg::FPTR_W-1:0]  r_wr_ptr;
    logic [lbs_pkg::FPTR_W-1:0]  r_rd_ptr;
    logic [lbs_pkg::FCNT_W-1:0]  r_count;
    logic                        do_push;
    logic                        do_pop;

    assign o_full  = (r_count == lbs_pkg::FCNT_W'(lbs_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == lbs_pkg::FPTR_W'(lbs_pkg::FIFO_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == lbs_pkg::FPTR_W'(lbs_pkg::FIFO_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

@@ rtl/lbs_back.sv @@
// Back end: frame store access, RGB565 packing and output register.
module lbs_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lbs_pkg::t_cmd               i_cmd,
    input  logic                        i_empty,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [lbs_pkg::PIX_W-1:0]   o_pixel,
    output logic                        o_inside
);

    logic [lbs_pkg::RGBA_W-1:0]  r_mem [lbs_pkg::DEPTH];
    logic [lbs_pkg::RGBA_W-1:0]  r_rd;
    logic                        r_b1_valid;
    logic                        r_b1_inside;
    logic                        r_out_valid;
    logic [lbs_pkg::PIX_W-1:0]   r_out_pixel;
    logic                        r_out_inside;
    logic                        adv;
    logic                        is_write;
    logic                        is_read;

    function automatic logic [lbs_pkg::PIX_W-1:0] to_565(input logic [lbs_pkg::RGBA_W-1:0] c);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = c[7:0] & 8'hFF;
        g = c[15:8];
        b = c[23:16];
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    assign adv      = !r_out_valid || i_ready;
    assign o_pop    = !i_empty && adv;
    assign is_write = (i_cmd.kind == lbs_pkg::K_WRITE);
    assign is_read  = (i_cmd.kind == lbs_pkg::K_READ);

    // single port: one write or one read per cycle while the output is not stalled
    always_ff @(posedge i_clk) begin
        if (o_pop && is_write) begin
            r_mem[i_cmd.addr] <= i_cmd.rgba;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && is_read) begin
            r_rd <= r_mem[i_cmd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_b1_valid  <= o_pop && !is_write;
            r_out_valid <= r_b1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b1_inside  <= is_read;
            r_out_inside <= r_b1_inside;
            r_out_pixel  <= r_b1_inside ? to_565(r_rd) : '0;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_pixel  = r_out_pixel;
    assign o_inside = r_out_inside;

endmodule

@@ rtl/letterbox_nearest_scaler_rgb565.sv @@
// Letterbox nearest-neighbour scaler top level: front end, command queue, back end, geometry.
//
// Aspect-fit nearest-neighbour scaler with a 512 x 512 RGB frame store and RGB565 output.
// Write items (tuser 0) store one source pixel at (coord_x, coord_y); writes outside the
// store are dropped and give no result. Read items (tuser 1) give one result: the nearest
// source pixel packed as RGB565 with inside_res 1, or black with inside_res 0 when the screen
// pixel lies in the centred letterbox or pillarbox border or off the screen. Items flow at
// one per clock while neither the geometry solve nor an output stall holds them, set by the
// single frame store port that serves one write or one read a cycle. A read result passes
// the first front stage, the second front stage, the queue, the store read and the output
// register before it is offered. After reset and after every register write the geometry
// (scale factor, picture size and offsets) is solved by one shared restoring divider, four
// 26-bit divisions one bit a cycle, and s_axis_tready stays low until it is done.
// Registers are meant to be written only while no item is in flight. The store has no
// reset; read only pixels that were written.
module letterbox_nearest_scaler_rgb565 (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [lbs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lbs_pkg::CFG_W-1:0]       i_cfg_data,

    // item input
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // tdata: coord_x [9:0], coord_y [19:10], rgba_in [43:20], zero fill [47:44]
    input  logic [lbs_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // tuser: opcode [0]
    input  logic [0:0]                      i_s_axis_tuser,

    // result output
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // tdata: pixel_565 [15:0]
    output logic [lbs_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    // tuser: inside_res [0]
    output logic [0:0]                      o_m_axis_tuser
);

    lbs_pkg::t_geom  geom;
    lbs_pkg::t_cmd   push_cmd;
    lbs_pkg::t_cmd   pop_cmd;
    logic            push;
    logic            full;
    logic            pop;
    logic            empty;
    logic            out_inside;

    // register file plus geometry solver; holds off input while solving
    lbs_geom u_geom (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_geom     (geom)
    );

    // accepts items, works out border/inside and the store address
    lbs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geom  (geom),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_op    (i_s_axis_tuser[0]),
        .i_cx    (i_s_axis_tdata[9:0]),
        .i_cy    (i_s_axis_tdata[19:10]),
        .i_rgba  (i_s_axis_tdata[43:20]),
        .o_push  (push),
        .o_cmd   (push_cmd),
        .i_full  (full)
    );

    // full comes from a registered count, so a stall on the output has no combinational path to tready
    lbs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (pop_cmd),
        .o_empty (empty)
    );

    // frame store, colour packing and the output register
    lbs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (pop_cmd),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_pixel  (o_m_axis_tdata),
        .o_inside (out_inside)
    );

    assign o_m_axis_tuser = out_inside;

endmodule

@@ rtl/lbs_checker.sv @@
// Port-level checker for the letterbox scaler, bound to the top level.
`include "letterbox_nearest_scaler_rgb565_assert.svh"

module lbs_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            o_s_axis_tready,
    input  logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    input  logic [lbs_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    input  logic [0:0]                      o_m_axis_tuser
);

    // a held result keeps its value
    `LBS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "result changed while stalled")

    // border pixels are black
    `LBS_ASSERT_NOW(a_border_black, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tuser[0], o_m_axis_tdata == '0, "border result not black")

    // a register write starts a geometry solve, so input is held off
    `LBS_ASSERT_NEXT(a_cfg_holds_input, i_clk, i_rst_n, i_cfg_we, !o_s_axis_tready, "input taken during geometry solve")

    // out of reset nothing is offered and nothing is taken
    `LBS_ASSERT_RAW_NEXT(a_reset_quiet, i_clk, !i_rst_n, !o_m_axis_tvalid && !o_s_axis_tready, "activity straight after reset")

endmodule

bind letterbox_nearest_scaler_rgb565 lbs_checker u_lbs_checker (.*);

@@ tb/sv/letterbox_nearest_scaler_rgb565_test.sv @@
// Self-checking testbench for the letterbox nearest-neighbour RGB565 scaler.
`timescale 1ns / 100ps

module letterbox_nearest_scaler_rgb565_test;
    import lbs_pkg::*;

    // run limits
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 16;    // quiet time after the last pending read is out
    localparam int ITEMS_PER_PHASE = 100;
    localparam int NUM_PHASES      = 14;
    localparam int HOLD_CYCLES     = 400;   // long output stall, fills the block up
    localparam int PRESSURE_PHASE  = 4;
    localparam int MAX_REPORTS     = 40;

    // one pending screen pixel
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             in_pic;
    } t_expect;

    // one row of the directed table; typed rows carry their answer
    typedef struct packed {
        logic               op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [RGBA_W-1:0]  rgba;
        logic               typed;
        logic [PIX_W-1:0]   pix;
        logic               in_pic;
    } t_row;

    // raw register values, indexed by register index
    typedef logic [0:3][CFG_W-1:0] t_geom_set;

    localparam int NUM_ROWS = 25;

    // At the reset geometry (320x240 on 424x240) the scale is exactly 1.0, the picture
    // starts at column 52 and fills rows 0..239, so the answers can be read off directly.
    localparam t_row DIRECTED_ROWS [NUM_ROWS] = '{
        '{OP_WRITE, 10'd0,    10'd0,    24'hFFFFFF, 1'b0, 16'h0000, 1'b0},
        '{OP_READ,  10'd52,   10'd0,    24'h000000, 1'b1, 16'hFFFF, 1'b1},  // white
        '{OP_WRITE, 10'd0,    10'd0,    24'h000000, 1'b0, 16'h0000, 1'b0},
        '{OP_READ,  10'd52,   10'd0,    24'hFFFFFF, 1'b1, 16'h0000, 1'b1},  // black inside
        '{OP_WRITE, 10'd319,  10'd239,  24'h0000FF, 1'b0, 16'h0000, 1'b0},
        '{OP_READ,  10'd371,  10'd239,  24'h000000, 1'b1, 16'hF800, 1'b1},  // red, far corner
        '{OP_WRITE, 10'd1,    10'd0,    24'h00FF00, 1'b0, 16'h0000, 1'b0},
        '{OP_READ,  10'd53,   10'd0,    24'h000000, 1'b1, 16'h07E0, 1'b1},  // green
        '{OP_WRITE, 10'd2,    10'd0,    24'hFF0000, 1'b0, 16'h0000, 1'b0},
        '{OP_READ,  10'd54,   10'd0,    24'h000000, 1'b1, 16'h001F, 1'b1},  // blue
        '{OP_READ,  10'd0,    10'd0,    24'h000000, 1'b1, 16'h0000, 1'b0},  // left bar
        '{OP_READ,  10'd51,   10'd120,  24'h000000, 1'b1, 16'h0000, 1'b0},
        '{OP_READ,  10'd372,  10'd5,    24'h000000, 1'b1, 16'h0000, 1'b0},  // right bar
        '{OP_READ,  10'd423,  10'd239,  24'h000000, 1'b1, 16'h0000, 1'b0},
        '{OP_READ,  10'd424,  10'd0,    24'h000000, 1'b1, 16'h0000, 1'b0},  // off screen
        '{OP_READ,  10'd0,    10'd240,  24'h000000, 1'b1, 16'h0000, 1'b0},
        '{OP_READ,  10'd1023, 10'd1023, 24'hFFFFFF, 1'b1, 16'h0000, 1'b0},
        '{OP_WRITE, 10'd512,  10'd0,    24'h123456, 1'b0, 16'h0000, 1'b0},  // outside store
        '{OP_WRITE, 10'd0,    10'd512,  24'h654321, 1'b0, 16'h0000, 1'b0},
        '{OP_WRITE, 10'd1023, 10'd1023, 24'hABCDEF, 1'b0, 16'h0000, 1'b0},
        '{OP_READ,  10'd52,   10'd0,    24'h000000, 1'b1, 16'h0000, 1'b1},  // (0,0) untouched
        '{OP_WRITE, 10'd200,  10'd100,  24'hA5C3E1, 1'b0, 16'h0000, 1'b0},
        '{OP_READ,  10'd252,  10'd100,  24'h000000, 1'b0, 16'h0000, 1'b0},
        '{OP_WRITE, 10'd318,  10'd238,  24'h5A3C1E, 1'b0, 16'h0000, 1'b0},
        '{OP_READ,  10'd370,  10'd238,  24'h000000, 1'b0, 16'h0000, 1'b0}
    };

    // Fixed geometries: extremes, zero and oversize values (clamped by the block),
    // source values with bit 10 set (dropped by the 10-bit register), and aspect cases.
    localparam int NUM_FIXED_SETS = 10;
    localparam t_geom_set GEOM_SETS [NUM_FIXED_SETS] = '{
        '{11'd1,    11'd1,    11'd1,    11'd1},
        '{11'd512,  11'd512,  11'd1024, 11'd1024},
        '{11'd0,    11'd0,    11'd0,    11'd0},
        '{11'd1023, 11'd1023, 11'd2047, 11'd2047},
        '{11'd16,   11'd9,    11'd1024, 11'd768},
        '{11'd1024, 11'd1536, 11'd1025, 11'd1500},
        '{11'd512,  11'd1,    11'd7,    11'd1000},   // picture collapses to no rows
        '{11'd1,    11'd512,  11'd1024, 11'd1},
        '{11'd4,    11'd3,    11'd1024, 11'd1024},
        '{11'd320,  11'd240,  11'd424,  11'd240}
    };

    // DUT-facing signals, the ones driven here known from time zero
    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = REG_SRC_W;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_valid  = 1'b0;
    logic [S_TDATA_W-1:0] s_data   = '0;
    logic [0:0]           s_user   = OP_WRITE;
    logic                 m_ready  = 1'b0;
    logic                 s_ready;
    logic                 m_valid;
    logic [M_TDATA_W-1:0] m_data;
    logic [0:0]           m_user;

    // testbench copy of the block's state
    logic [SRC_W-1:0]     src_w_reg;
    logic [SRC_W-1:0]     src_h_reg;
    logic [SCR_W-1:0]     scr_w_reg;
    logic [SCR_W-1:0]     scr_h_reg;
    logic [RGBA_W-1:0]    pixel_store [int];    // only entries that were written
    t_expect              pending_pixels [$];

    // idling controls, owned by the stimulus
    int                   snd_idle_pct  = 0;
    int                   rcv_stall_pct = 0;
    bit                   hold_arm      = 1'b0;

    // bookkeeping
    int                   mismatch_count  = 0;
    int                   results_checked = 0;
    int                   items_sent      = 0;
    int                   useful_items    = 0;
    int                   cycle_count     = 0;

    letterbox_nearest_scaler_rgb565 dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),     // coord_x [9:0], coord_y [19:10], rgba_in [43:20]
        .i_s_axis_tuser  (s_user),     // opcode [0]
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),     // pixel_565 [15:0]
        .o_m_axis_tuser  (m_user)      // inside_res [0]
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------------------
    // Geometry and pixel prediction
    // ---------------------------------------------------------------------------------

    // register value as the block sees it: 0 acts as 1, anything above hi as hi
    function automatic int clamp_size(input int v, input int hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // one axis: screen position -> source index, 0 when in the border
    function automatic bit map_to_source(input longint unsigned pos, input longint unsigned src,
                                         input longint unsigned scr,
                                         input longint unsigned scale,
                                         input longint unsigned lim,
                                         output longint unsigned idx);
        longint unsigned dest;
        longint unsigned start;
        longint unsigned s;
        dest = (src << 16) / scale;
        if (dest > scr) dest = scr;
        start = (scr - dest) / 2;
        idx = 0;
        if (pos >= scr || pos < start || pos >= start + dest) return 1'b0;
        s = ((pos - start) * scale) >> 16;
        if (src < lim) lim = src;
        if (s > lim - 1) s = lim - 1;
        idx = s;
        return 1'b1;
    endfunction

    // screen pixel -> source pixel under the current registers
    function automatic bit locate_source(input logic [COORD_W-1:0] px,
                                         input logic [COORD_W-1:0] py,
                                         output int sx, output int sy);
        longint unsigned sw, sh, scw, sch, kx, ky, scale, ix, iy;
        bit in_x, in_y;
        sw  = clamp_size(int'(src_w_reg), SRC_LIMIT);
        sh  = clamp_size(int'(src_h_reg), SRC_LIMIT);
        scw = clamp_size(int'(scr_w_reg), SCR_LIMIT);
        sch = clamp_size(int'(scr_h_reg), SCR_LIMIT);
        kx = (sw << 16) / scw;
        ky = (sh << 16) / sch;
        scale = (kx > ky) ? kx : ky;
        if (scale == 0) scale = 1;
        in_x = map_to_source(px, sw, scw, scale, SRC_MAX_WIDTH, ix);
        in_y = map_to_source(py, sh, sch, scale, SRC_MAX_HEIGHT, iy);
        sx = int'(ix);
        sy = int'(iy);
        return in_x && in_y;
    endfunction

    function automatic t_expect predict_screen_pixel(input logic [COORD_W-1:0] px,
                                                     input logic [COORD_W-1:0] py);
        int sx, sy, key;
        logic [RGBA_W-1:0] c;
        t_expect e;
        e = '0;
        if (locate_source(px, py, sx, sy)) begin
            key = sy * SRC_MAX_WIDTH + sx;
            c = pixel_store.exists(key) ? pixel_store[key] : '0;
            e.pix    = {c[7:3], c[15:10], c[23:19]};   // r5 g6 b5
            e.in_pic = 1'b1;
        end
        return e;
    endfunction

    // ---------------------------------------------------------------------------------
    // Driving
    // ---------------------------------------------------------------------------------

    // Offer one item, after a random idle gap, and keep tvalid high on return so that
    // back-to-back items never see tvalid dropped and raised in the same step.
    task automatic send_item(input logic op, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic [RGBA_W-1:0] rgba,
                             input bit typed, input t_expect typed_exp);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {4'b0000, rgba, y, x};
        s_user  <= op;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        // item accepted at this edge
        items_sent++;
        if (op == OP_WRITE) begin
            if (x < SRC_MAX_WIDTH && y < SRC_MAX_HEIGHT) begin
                pixel_store[int'(y) * SRC_MAX_WIDTH + int'(x)] = rgba;
                useful_items++;
            end
        end else begin
            pending_pixels.push_back(typed ? typed_exp : predict_screen_pixel(x, y));
            useful_items++;
        end
    endtask

    // A read of a source entry never written is not allowed, so fill it in first.
    task automatic issue_read(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        int sx, sy;
        t_expect none;
        none = '0;
        if (locate_source(x, y, sx, sy) && !pixel_store.exists(sy * SRC_MAX_WIDTH + sx))
            send_item(OP_WRITE, COORD_W'(sx), COORD_W'(sy), RGBA_W'($urandom), 1'b0, none);
        send_item(OP_READ, x, y, RGBA_W'($urandom), 1'b0, none);
    endtask

    // drop tvalid, let every pending read come out, then let the pipe go quiet
    task automatic settle_idle();
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            REG_SRC_W: src_w_reg = value[SRC_W-1:0];
            REG_SRC_H: src_h_reg = value[SRC_W-1:0];
            REG_SCR_W: scr_w_reg = value[SCR_W-1:0];
            REG_SCR_H: scr_h_reg = value[SCR_W-1:0];
            default: ;
        endcase
    endtask

    // the block re-solves its geometry after this, holding tready low meanwhile
    task automatic program_geometry(input t_geom_set g);
        write_register(REG_SRC_W, g[REG_SRC_W]);
        write_register(REG_SRC_H, g[REG_SRC_H]);
        write_register(REG_SCR_W, g[REG_SCR_W]);
        write_register(REG_SCR_H, g[REG_SCR_H]);
        cfg_we <= 1'b0;
    endtask

    // Mostly writes inside the source picture and reads inside the screen, with some
    // writes off the store and reads anywhere. Ignored writes do not count.
    task automatic run_random(input int n);
        int goal, sw, sh, scw, sch, pick;
        t_expect none;
        none = '0;
        goal = useful_items + n;
        sw  = clamp_size(int'(src_w_reg), SRC_LIMIT);
        sh  = clamp_size(int'(src_h_reg), SRC_LIMIT);
        scw = clamp_size(int'(scr_w_reg), SCR_LIMIT);
        sch = clamp_size(int'(scr_h_reg), SCR_LIMIT);
        while (useful_items < goal) begin
            pick = $urandom_range(99);
            if (pick < 30)
                send_item(OP_WRITE, COORD_W'($urandom_range(sw - 1)),
                          COORD_W'($urandom_range(sh - 1)), RGBA_W'($urandom), 1'b0, none);
            else if (pick < 38)
                send_item(OP_WRITE, COORD_W'($urandom), COORD_W'($urandom),
                          RGBA_W'($urandom), 1'b0, none);
            else if (pick < 85)
                issue_read(COORD_W'($urandom_range(scw - 1)), COORD_W'($urandom_range(sch - 1)));
            else
                issue_read(COORD_W'($urandom), COORD_W'($urandom));
        end
    endtask

    // ---------------------------------------------------------------------------------
    // Result side
    // ---------------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [PIX_W-1:0] got,
                                   input logic [PIX_W-1:0] want);
        if (mismatch_count < MAX_REPORTS)
            $display("mismatch: %0s got %h want %h (cycle %0d)", what, got, want, cycle_count);
        mismatch_count++;
    endtask

    // Output stalls: random per phase, plus one long hold-off counted here.
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (hold_arm && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // every accepted result against the oldest pending pixel
    always @(posedge i_clk) begin
        t_expect want;
        if (i_rst_n && m_valid && m_ready) begin
            results_checked++;
            if (pending_pixels.size() == 0) begin
                report_mismatch("result with nothing pending", m_data, '0);
            end else begin
                want = pending_pixels.pop_front();
                if (m_data !== want.pix)
                    report_mismatch("pixel_565", m_data, want.pix);
                if (m_user[0] !== want.in_pic)
                    report_mismatch("inside_res", {15'd0, m_user[0]}, {15'd0, want.in_pic});
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reads pending",
                     cycle_count, pending_pixels.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------------------

    initial begin
        t_row row;
        t_expect typed_exp;
        t_geom_set g;

        src_w_reg = RST_SRC_W;
        src_h_reg = RST_SRC_H;
        scr_w_reg = RST_SCR_W;
        scr_h_reg = RST_SCR_H;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table at the reset geometry, no idling
        for (int i = 0; i < NUM_ROWS; i++) begin
            row = DIRECTED_ROWS[i];
            typed_exp.pix    = row.pix;
            typed_exp.in_pic = row.in_pic;
            send_item(row.op, row.x, row.y, row.rgba, row.typed, typed_exp);
        end

        // random phases, each under a fresh geometry and its own idling pattern
        for (int p = 0; p < NUM_PHASES; p++) begin
            settle_idle();
            if (p < NUM_FIXED_SETS) begin
                g = GEOM_SETS[p];
            end else if (p < NUM_PHASES - 1) begin
                g[REG_SRC_W] = CFG_W'($urandom_range(SRC_LIMIT, 1));
                g[REG_SRC_H] = CFG_W'($urandom_range(SRC_LIMIT, 1));
                g[REG_SCR_W] = CFG_W'($urandom_range(SCR_LIMIT, 1));
                g[REG_SCR_H] = CFG_W'($urandom_range(SCR_LIMIT, 1));
            end else begin
                // raw 11-bit values, out of range ones included
                g[REG_SRC_W] = CFG_W'($urandom);
                g[REG_SRC_H] = CFG_W'($urandom);
                g[REG_SCR_W] = CFG_W'($urandom);
                g[REG_SCR_H] = CFG_W'($urandom);
            end
            program_geometry(g);
            case (p % 4)
                0: begin snd_idle_pct <= 0;  rcv_stall_pct <= 0;  end
                1: begin snd_idle_pct <= 73; rcv_stall_pct <= 0;  end
                2: begin snd_idle_pct <= 0;  rcv_stall_pct <= 73; end
                default: begin snd_idle_pct <= 17; rcv_stall_pct <= 17; end
            endcase
            // sender keeps offering while the output is held off for a long stretch
            if (p == PRESSURE_PHASE) hold_arm <= 1'b1;
            run_random(ITEMS_PER_PHASE);
        end
        settle_idle();

        $display("%0d items sent, %0d results checked, over %0d geometries",
                 items_sent, results_checked, NUM_PHASES + 1);
        $display("phases with no idling, sparse input, heavy output stalls and a long hold-off");
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
